// ----- design/gdd_pkg.sv -----
package gdd_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 22;

	// day numbers of years up to 16383 (plus the 400-year bias) fit in 23 bits
	localparam int DNUM_W = 23;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// floor(y / 100) as (y * RECIP_100) >> RECIP_SHIFT, exact for y below 2^15
	localparam int RECIP_SHIFT = 21;
	localparam logic [YEAR_W:0] RECIP_100 = 15'd20972;
	localparam int PROD_W = 29;
	localparam int Q_W    = 8;
	localparam int R_W    = 7;

	localparam logic [YEAR_W:0] YEAR_BIAS = 15'd399;

	typedef struct packed {
		logic [YEAR_W-1:0]  start_year;
		logic [MONTH_W-1:0] start_month;
		logic [DAY_W-1:0]   start_day;
		logic [YEAR_W-1:0]  end_year;
		logic [MONTH_W-1:0] end_month;
		logic [DAY_W-1:0]   end_day;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] day_count;
		logic               date_error;
	} out_item_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	// load enables of the three date stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		begin
			case (m)
				4'd2: begin
					len = leap ? 5'd29 : 5'd28;
				end
				4'd4, 4'd6, 4'd9, 4'd11: begin
					len = 5'd30;
				end
				default: begin
					len = 5'd31;
				end
			endcase
			return len;
		end
	endfunction

	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
		logic [8:0] n;
		begin
			case (m)
				4'd2:    n = 9'd31;
				4'd3:    n = 9'd59;
				4'd4:    n = 9'd90;
				4'd5:    n = 9'd120;
				4'd6:    n = 9'd151;
				4'd7:    n = 9'd181;
				4'd8:    n = 9'd212;
				4'd9:    n = 9'd243;
				4'd10:   n = 9'd273;
				4'd11:   n = 9'd304;
				4'd12:   n = 9'd334;
				default: n = 9'd0;
			endcase
			return n;
		end
	endfunction

endpackage

// ----- design/gdd_day_number.sv -----
module gdd_day_number
	import gdd_pkg::*;
(
	input  logic              clk,
	input  stage_en_t         en,
	input  date_t             date,
	output logic [DNUM_W-1:0] dnum_s3,
	output logic              ok_s3
);

	// stage 1: reciprocal product for the century quotient
	logic [YEAR_W-1:0]  year_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [DAY_W-1:0]   day_s1;
	logic [PROD_W-1:0]  prod_s1;

	// stage 2: quotient, remainder, leap year and validity
	logic [YEAR_W-1:0]  year_s2;
	logic [MONTH_W-1:0] month_s2;
	logic [DAY_W-1:0]   day_s2;
	logic [Q_W-1:0]     q_s2;
	logic [R_W-1:0]     r_s2;
	logic               leap_s2;
	logic               ok_s2;

	logic [Q_W-1:0]    q;
	logic [YEAR_W-1:0] hund;
	logic [YEAR_W-1:0] rem_full;
	logic [R_W-1:0]    r;
	logic              leap;
	logic              ok;

	logic [DNUM_W-1:0] yb;
	logic [DNUM_W-1:0] div100;
	logic [DNUM_W-1:0] div400;
	logic [DNUM_W-1:0] dnum;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			year_s1  <= date.year;
			month_s1 <= date.month;
			day_s1   <= date.day;
			prod_s1  <= PROD_W'(date.year) * PROD_W'(RECIP_100);
		end
	end

	always_comb begin
		q        = prod_s1[RECIP_SHIFT +: Q_W];
		hund     = YEAR_W'(q) * YEAR_W'(100);
		rem_full = year_s1 - hund;
		r        = rem_full[R_W-1:0];
		// divisible by 400 exactly when the century remainder is 0 and the century count is a multiple of 4
		leap     = (year_s1[1:0] == 2'd0 && r != '0) || (r == '0 && q[1:0] == 2'd0);
		ok       = (month_s1 inside {[4'd1:4'd12]}) && day_s1 != '0
			&& day_s1 <= month_len(month_s1, leap);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			year_s2  <= year_s1;
			month_s2 <= month_s1;
			day_s2   <= day_s1;
			q_s2     <= q;
			r_s2     <= r;
			leap_s2  <= leap;
			ok_s2    <= ok;
		end
	end

	// with y = 100q + r: (y + 399) / 100 = q + 3, plus 1 when r is not 0,
	// and (y + 399) / 400 = q / 4, plus 1 when y is not a multiple of 400
	always_comb begin
		yb     = DNUM_W'(year_s2) + DNUM_W'(YEAR_BIAS);
		div100 = DNUM_W'(q_s2) + ((r_s2 == '0) ? DNUM_W'(3) : DNUM_W'(4));
		div400 = DNUM_W'(q_s2 >> 2)
			+ DNUM_W'((q_s2[1:0] != 2'd0) || (r_s2 != '0));
		dnum   = yb * DNUM_W'(365) + (yb >> 2) - div100 + div400
			+ DNUM_W'(days_before(month_s2))
			+ DNUM_W'(leap_s2 && month_s2 > 4'd2)
			+ DNUM_W'(day_s2);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			dnum_s3 <= dnum;
			ok_s3   <= ok_s2;
		end
	end

endmodule

// ----- design/gdd_count.sv -----
module gdd_count
	import gdd_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [DNUM_W-1:0] start_dnum,
	input  logic              start_ok,
	input  logic [DNUM_W-1:0] end_dnum,
	input  logic              end_ok,
	output out_item_t         data_s4
);

	logic [DNUM_W-1:0] diff;
	out_item_t         nxt;

	always_comb begin
		diff = end_dnum - start_dnum;
		nxt.date_error = !(start_ok && end_ok);
		if (nxt.date_error || end_dnum <= start_dnum) begin
			nxt.day_count = '0;
		end else if (diff > DNUM_W'(COUNT_MAX)) begin
			nxt.day_count = COUNT_MAX;
		end else begin
			nxt.day_count = diff[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s4 <= nxt;
		end
	end

endmodule

// ----- design/gregorian_day_difference.sv -----
// Days between two proleptic Gregorian dates. Each date becomes a day
// number in closed form (365 per year plus leap days, month offset and
// day), and the start's number is taken from the end's; the count is 0
// when the end is not after the start, and 0 with date_error set when
// either date has a bad month or a day that is 0 or beyond its month.
// A date pair is taken every cycle while the output is not stalled, and
// its result passes four register stages: one for the reciprocal
// multiply that yields the century quotient, one for the leap-year and
// validity checks, one for the day number sum and one for the subtraction
// and saturation. A stall on the output holds the whole pipe; a pipe
// bubble is filled while stalled.
module gregorian_day_difference
	import gdd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	stage_en_t en;
	date_t     start_date;
	date_t     end_date;

	logic [DNUM_W-1:0] start_dnum_s3;
	logic [DNUM_W-1:0] end_dnum_s3;
	logic              start_ok_s3;
	logic              end_ok_s3;

	// a stage loads when it is empty or its content moves on
	assign rdy4 = !v_s4 || out_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign in_ready  = rdy1;
	assign out_valid = v_s4;

	assign en.s1 = rdy1 && in_valid;
	assign en.s2 = rdy2 && v_s1;
	assign en.s3 = rdy3 && v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	assign start_date = '{year: in_data.start_year, month: in_data.start_month,
		day: in_data.start_day};
	assign end_date = '{year: in_data.end_year, month: in_data.end_month,
		day: in_data.end_day};

	gdd_day_number u_start (
		.clk     (clk),
		.en      (en),
		.date    (start_date),
		.dnum_s3 (start_dnum_s3),
		.ok_s3   (start_ok_s3)
	);

	gdd_day_number u_end (
		.clk     (clk),
		.en      (en),
		.date    (end_date),
		.dnum_s3 (end_dnum_s3),
		.ok_s3   (end_ok_s3)
	);

	gdd_count u_count (
		.clk        (clk),
		.en         (rdy4 && v_s3),
		.start_dnum (start_dnum_s3),
		.start_ok   (start_ok_s3),
		.end_dnum   (end_dnum_s3),
		.end_ok     (end_ok_s3),
		.data_s4    (out_data)
	);

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import gdd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int N_RANDOM    = 1200;
	localparam int DRAIN_WAIT  = 24;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_LEN    = 160;
	localparam int MAX_REPORTS = 10;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	in_item_t  pending_q [$];
	out_item_t span_q [$];

	int unsigned mdays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	int n_items    = 0;
	int n_sent     = 0;
	int n_got      = 0;
	int n_bad      = 0;
	int n_flagged  = 0;
	int n_zero     = 0;
	int n_sat      = 0;
	int cyc_cnt    = 0;

	gregorian_day_difference u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #6 clk = ~clk;

	function automatic bit is_leap(int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	function automatic int unsigned days_in(int unsigned y, int unsigned m);
		if (m == 2 && is_leap(y)) begin
			return 29;
		end
		return mdays[m - 1];
	endfunction

	function automatic bit date_valid(int unsigned y, int unsigned m, int unsigned d);
		if (m < 1 || m > 12 || d < 1) begin
			return 1'b0;
		end
		return d <= days_in(y, m);
	endfunction

	// shift by one 400-year cycle so that year 0 stays positive
	function automatic longint unsigned ordinal(int unsigned y, int unsigned m,
		int unsigned d);
		longint unsigned yb;
		longint unsigned n;
		yb = 64'(y) + 64'(399);
		n = yb * 365 + yb / 4 - yb / 100 + yb / 400;
		for (int unsigned i = 1; i < m; i++) begin
			n += 64'(days_in(y, i));
		end
		return n + 64'(d);
	endfunction

	function automatic out_item_t predict_span(in_item_t it);
		out_item_t r;
		longint unsigned a;
		longint unsigned b;
		longint unsigned diff;
		r = '0;
		if (!date_valid(32'(it.start_year), 32'(it.start_month), 32'(it.start_day)) ||
			!date_valid(32'(it.end_year), 32'(it.end_month), 32'(it.end_day))) begin
			r.date_error = 1'b1;
		end else begin
			a = ordinal(32'(it.start_year), 32'(it.start_month), 32'(it.start_day));
			b = ordinal(32'(it.end_year), 32'(it.end_month), 32'(it.end_day));
			if (b > a) begin
				diff = b - a;
				if (diff > COUNT_MAX) begin
					r.day_count = COUNT_MAX;
				end else begin
					r.day_count = diff[COUNT_W-1:0];
				end
			end
		end
		return r;
	endfunction

	function automatic in_item_t date_pair(int unsigned sy, int unsigned sm, int unsigned sd,
		int unsigned ey, int unsigned em, int unsigned ed);
		in_item_t it;
		it.start_year  = sy[YEAR_W-1:0];
		it.start_month = sm[MONTH_W-1:0];
		it.start_day   = sd[DAY_W-1:0];
		it.end_year    = ey[YEAR_W-1:0];
		it.end_month   = em[MONTH_W-1:0];
		it.end_day     = ed[DAY_W-1:0];
		return it;
	endfunction

	function automatic date_t any_date(int unsigned ylo, int unsigned yhi);
		date_t dt;
		int unsigned y;
		int unsigned m;
		y = $urandom_range(yhi, ylo);
		m = $urandom_range(12, 1);
		dt.year  = y[YEAR_W-1:0];
		dt.month = m[MONTH_W-1:0];
		dt.day   = DAY_W'($urandom_range(days_in(y, m), 1));
		return dt;
	endfunction

	function automatic date_t raw_date();
		date_t dt;
		dt.year  = YEAR_W'($urandom_range(16383, 0));
		dt.month = MONTH_W'($urandom_range(15, 0));
		dt.day   = DAY_W'($urandom_range(31, 0));
		return dt;
	endfunction

	function automatic in_item_t join_dates(date_t s, date_t e);
		return date_pair(32'(s.year), 32'(s.month), 32'(s.day),
			32'(e.year), 32'(e.month), 32'(e.day));
	endfunction

	// mostly short gaps, a few long ones
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(99, 0);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(30, 8);
	endfunction

	// sender: present queued items, predict on each transfer
	always @(posedge clk or negedge arst_n) begin : send_side
		int unsigned gap_left;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				span_q.push_back(predict_span(in_data));
				n_sent <= n_sent + 1;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					in_data  <= pending_q.pop_front();
					in_valid <= 1'b1;
					gap_left = ((n_sent % 256) < 48) ? 0 : idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : recv_side
		int unsigned stall_left;
		int unsigned hold_left;
		bit held;
		out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
			held = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_got <= n_got + 1;
				if (out_data.date_error) n_flagged <= n_flagged + 1;
				if (out_data.day_count == '0) n_zero <= n_zero + 1;
				if (out_data.day_count == COUNT_MAX) n_sat <= n_sat + 1;
				if (span_q.size() == 0) begin
					if (n_bad < MAX_REPORTS) begin
						$display("ERROR: unexpected result count=%0d err=%0b",
							out_data.day_count, out_data.date_error);
					end
					n_bad <= n_bad + 1;
				end else begin
					want = span_q.pop_front();
					if (out_data.day_count !== want.day_count ||
						out_data.date_error !== want.date_error) begin
						if (n_bad < MAX_REPORTS) begin
							$display("ERROR: result %0d count exp %0d got %0d, err exp %0b got %0b",
								n_got, want.day_count, out_data.day_count,
								want.date_error, out_data.date_error);
						end
						n_bad <= n_bad + 1;
					end
				end
				stall_left = ((n_got % 256) >= 128 && (n_got % 256) < 176) ? 0 : idle_len();
				// hold off once for a long stretch so the pipe backs up
				if (!held && n_got + 1 == HOLD_AT) begin
					hold_left = HOLD_LEN;
					held = 1'b1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (cyc_cnt == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		date_t s;
		date_t e;
		date_t t;
		int unsigned kind;
		int unsigned y;

		// directed: range extremes, leap rules, bad fields, saturation
		pending_q.push_back(date_pair(1, 1, 1, 9999, 12, 31));
		pending_q.push_back(date_pair(9999, 12, 31, 1, 1, 1));
		pending_q.push_back(date_pair(2020, 6, 15, 2020, 6, 15));
		pending_q.push_back(date_pair(1, 1, 1, 1, 1, 2));
		pending_q.push_back(date_pair(1999, 12, 31, 2000, 1, 1));
		pending_q.push_back(date_pair(2000, 2, 29, 2000, 3, 1));
		pending_q.push_back(date_pair(1900, 2, 29, 1900, 3, 1));
		pending_q.push_back(date_pair(1900, 2, 28, 1900, 3, 1));
		pending_q.push_back(date_pair(2024, 2, 29, 2024, 3, 1));
		pending_q.push_back(date_pair(2023, 2, 27, 2023, 2, 29));
		pending_q.push_back(date_pair(2020, 0, 10, 2021, 1, 1));
		pending_q.push_back(date_pair(2020, 1, 10, 2021, 13, 1));
		pending_q.push_back(date_pair(2020, 15, 31, 2021, 1, 1));
		pending_q.push_back(date_pair(2020, 1, 10, 2021, 1, 0));
		pending_q.push_back(date_pair(2020, 4, 31, 2021, 1, 1));
		pending_q.push_back(date_pair(2020, 1, 31, 2020, 12, 31));
		pending_q.push_back(date_pair(0, 2, 29, 1, 1, 1));
		pending_q.push_back(date_pair(0, 1, 1, 16383, 12, 31));
		pending_q.push_back(date_pair(1, 1, 1, 16383, 12, 31));
		pending_q.push_back(date_pair(9999, 12, 31, 16000, 2, 29));
		pending_q.push_back(date_pair(16383, 2, 29, 16383, 3, 1));
		pending_q.push_back(date_pair(16383, 1, 1, 16383, 12, 31));
		pending_q.push_back(date_pair(0, 0, 0, 16383, 15, 31));
		pending_q.push_back(date_pair(8191, 7, 31, 10922, 8, 31));

		for (int i = 0; i < N_RANDOM; i++) begin
			kind = $urandom_range(99, 0);
			if (kind < 45) begin
				s = any_date(1, 9999);
				e = any_date(1, 9999);
				if ($urandom_range(4, 0) != 0 &&
					ordinal(32'(e.year), 32'(e.month), 32'(e.day)) <
					ordinal(32'(s.year), 32'(s.month), 32'(s.day))) begin
					t = s;
					s = e;
					e = t;
				end
			end else if (kind < 55) begin
				// nearby dates, small counts
				s = any_date(1, 9998);
				e = any_date(32'(s.year), 32'(s.year) + $urandom_range(1, 0));
			end else if (kind < 67) begin
				// around February in leap and century years
				case ($urandom_range(2, 0))
					0: y = 400 * $urandom_range(24, 0);
					1: y = 100 * $urandom_range(99, 1);
					default: y = 4 * $urandom_range(2499, 1);
				endcase
				s = date_t'{YEAR_W'(y), MONTH_W'(2), DAY_W'($urandom_range(29, 27))};
				e = date_t'{YEAR_W'(y + $urandom_range(1, 0)), MONTH_W'($urandom_range(3, 2)),
					DAY_W'($urandom_range(2, 1))};
			end else if (kind < 79) begin
				s = any_date(0, 16383);
				e = any_date(0, 16383);
			end else if (kind < 92) begin
				s = raw_date();
				e = ($urandom_range(1, 0) != 0) ? raw_date() : any_date(1, 9999);
				if ($urandom_range(1, 0) != 0) begin
					t = s;
					s = e;
					e = t;
				end
			end else begin
				s = any_date(0, 16383);
				e = s;
			end
			pending_q.push_back(join_dates(s, e));
		end
		n_items = pending_q.size();

		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (n_sent != n_items || span_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Checked %0d date pairs: %0d flagged invalid, %0d zero counts, %0d saturated.",
			n_got, n_flagged, n_zero, n_sat);
		$display("Mismatches: %0d, ran %0d cycles with one long output hold-off.",
			n_bad, cyc_cnt);
		if (n_bad == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
